FILE: design/ljpf_pkg.sv
package ljpf_pkg;

	localparam int MAG_W = 47;
	localparam logic [MAG_W-1:0] LIM = {MAG_W{1'b1}};

	typedef enum logic [0:0] {
		REG_BOX_SIDE  = 1'b0,
		REG_CUTOFF_SQ = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] pos_ix;
		logic [31:0] pos_iy;
		logic [31:0] pos_iz;
		logic [31:0] pos_jx;
		logic [31:0] pos_jy;
		logic [31:0] pos_jz;
	} in_t;

	typedef struct packed {
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic signed [47:0] energy_term;
		logic signed [47:0] virial_term;
		logic               in_range;
		logic               saturated;
	} out_t;

	// per-pair context carried down the pipe
	typedef struct packed {
		logic [2:0][32:0] d;
		logic [31:0]      rd;
		logic             inr;
		logic             zero;
		logic             sat;
	} ctx_t;

	typedef struct packed {
		logic [MAG_W-1:0] rrd;
		ctx_t             c;
	} t1_t;

	typedef struct packed {
		logic [MAG_W-1:0] hmag;
		logic             hneg;
		ctx_t             c;
	} t3_t;

	typedef struct packed {
		logic [MAG_W-1:0] en_mag;
		logic             en_neg;
		logic             rneg;
		ctx_t             c;
	} t4_t;

endpackage

FILE: design/ljpf_umulq.sv
module ljpf_umulq import ljpf_pkg::*; #(
	parameter int FRAC_BITS = 24,
	parameter int TW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [MAG_W-1:0] a,
	input  logic [MAG_W-1:0] b,
	input  logic [TW-1:0]    tag_in,
	output logic             vld_out,
	output logic [MAG_W-1:0] prod,
	output logic             sat,
	output logic [TW-1:0]    tag_out
);

	localparam int HW = MAG_W - 32;
	localparam int PW = 2 * MAG_W;
	localparam int SW = PW - FRAC_BITS;

	logic [63:0]        ll_s1;
	logic [MAG_W-1:0]   lh_s1, hl_s1;
	logic [2*HW-1:0]    hh_s1;
	logic [PW-1:0]      p_s2;
	logic [TW-1:0]      tag_s1, tag_s2;
	logic [2:0]         v_s;
	logic [SW-1:0]      shifted;
	logic               ovf;

	always_comb begin
		shifted = p_s2[PW-1:FRAC_BITS];
		ovf = |shifted[SW-1:MAG_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[1:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1   <= 64'(a[31:0]) * 64'(b[31:0]);
			lh_s1   <= MAG_W'(a[31:0]) * MAG_W'(b[MAG_W-1:32]);
			hl_s1   <= MAG_W'(a[MAG_W-1:32]) * MAG_W'(b[31:0]);
			hh_s1   <= (2*HW)'(a[MAG_W-1:32]) * (2*HW)'(b[MAG_W-1:32]);
			tag_s1  <= tag_in;
			p_s2    <= PW'(ll_s1) + (PW'(lh_s1) << 32) + (PW'(hl_s1) << 32)
				+ (PW'(hh_s1) << 64);
			tag_s2  <= tag_s1;
			prod    <= ovf ? LIM : shifted[MAG_W-1:0];
			sat     <= ovf;
			tag_out <= tag_s2;
		end
	end

	assign vld_out = v_s[2];

endmodule

FILE: design/lennard_jones_pair_force.sv
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall  | in_data (in_t), two positions
// out      | output    | out_valid / out_stall| out_data (out_t), LJ terms and flags
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pair per cycle while the pipe is not stalled; the 47-stage restoring divider for 1/rd
// and five chained 3-stage multipliers set the depth.
// Reset clears valid bits and loads box_side and cutoff_sq defaults.
// out_stall with a result held freezes the whole pipe; in_stall follows it.
// cfg_ready is always high.
module lennard_jones_pair_force import ljpf_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  reg_idx_t    cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int RDW = 67 - FRAC_BITS;
	localparam int NDV = MAG_W;
	localparam int P0_SH = (2*FRAC_BITS >= MAG_W) ? 2*FRAC_BITS - MAG_W : 0;
	localparam logic [RDW:0] P0 = (2*FRAC_BITS >= MAG_W) ?
		((RDW+1)'(1) << P0_SH) : '0;
	localparam logic [47:0] HALF = 48'(1) << (FRAC_BITS - 1);
	localparam logic [47:0] ONE = 48'(1) << FRAC_BITS;
	localparam logic signed [47:0] SLIM = 48'(LIM);

	logic en;
	logic [31:0] box_side_q, cutoff_sq_q;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_side_q  <= 32'd424673280;
			cutoff_sq_q <= 32'd235929600;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BOX_SIDE:  box_side_q  <= cfg_data;
				REG_CUTOFF_SQ: cutoff_sq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: difference, fold, magnitude, square, sum
	logic [2:0][31:0] pi, pj;
	logic signed [34:0] d_s1 [3];
	logic signed [34:0] d_s2 [3];
	logic signed [34:0] d_s3 [3];
	logic signed [34:0] f1 [3];
	logic signed [34:0] f2 [3];
	logic signed [35:0] sx;
	logic signed [34:0] sx35;
	logic [2:0][32:0] d_s4, d_s5, d_s6;
	logic [2:0][31:0] dm_s4;
	logic [2:0][31:0] dm3;
	logic [2:0][63:0] sq_s5;
	logic [RDW-1:0] rd_s6, rd_n;
	logic [RDW-1:0] hsum;
	logic [FRAC_BITS+1:0] lsum;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign pi = {in_data.pos_iz, in_data.pos_iy, in_data.pos_ix};
	assign pj = {in_data.pos_jz, in_data.pos_jy, in_data.pos_jx};

	always_comb begin
		sx = $signed({4'b0, box_side_q});
		sx35 = $signed({3'b0, box_side_q});
		hsum = '0;
		lsum = '0;
		for (int c = 0; c < 3; c++) begin
			f1[c] = ($signed({d_s1[c], 1'b0}) < -sx) ? d_s1[c] + sx35 : d_s1[c];
			f2[c] = ($signed({d_s2[c], 1'b0}) > sx) ? d_s2[c] - sx35 : d_s2[c];
			dm3[c] = d_s3[c][34] ? 32'(-d_s3[c]) : d_s3[c][31:0];
			hsum = hsum + RDW'(sq_s5[c][63:FRAC_BITS]);
			lsum = lsum + (FRAC_BITS+2)'(sq_s5[c][FRAC_BITS-1:0]);
		end
		rd_n = hsum + RDW'(lsum[FRAC_BITS+1:FRAC_BITS]);
	end

	// divider stage 0 holds the range checks; stages 1..NDV each resolve one quotient bit
	logic [RDW:0]       dv_p_s [0:NDV];
	logic [MAG_W-1:0]   dv_q_s [0:NDV];
	logic [RDW-1:0]     dv_r_s [0:NDV];
	ctx_t               dv_c_s [0:NDV];
	logic [NDV:0]       dv_v_s;
	logic [RDW:0]       nx_p [0:NDV-1];
	logic [MAG_W-1:0]   nx_q [0:NDV-1];
	ctx_t               c0;

	always_comb begin
		logic [RDW:0] psh;
		logic ge;
		for (int j = 0; j < NDV; j++) begin
			psh = {dv_p_s[j][RDW-1:0], (NDV - 1 - j) == 2*FRAC_BITS};
			ge = psh >= {1'b0, dv_r_s[j]};
			nx_p[j] = ge ? psh - {1'b0, dv_r_s[j]} : psh;
			nx_q[j] = {dv_q_s[j][MAG_W-2:0], ge};
		end
		c0.d = d_s6;
		c0.rd = rd_s6[31:0];
		c0.inr = rd_s6 <= RDW'(cutoff_sq_q);
		c0.zero = rd_s6 == '0;
		c0.sat = P0 >= {1'b0, rd_s6};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			dv_v_s <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			dv_v_s <= {dv_v_s[NDV-1:0], v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				d_s1[c] <= $signed({3'b0, pi[c]}) - $signed({3'b0, pj[c]});
				d_s2[c] <= f1[c];
				d_s3[c] <= f2[c];
				d_s4[c] <= d_s3[c][32:0];
				dm_s4[c] <= dm3[c];
				sq_s5[c] <= 64'(dm_s4[c]) * 64'(dm_s4[c]);
			end
			d_s5 <= d_s4;
			d_s6 <= d_s5;
			rd_s6 <= rd_n;
			dv_p_s[0] <= P0;
			dv_q_s[0] <= '0;
			dv_r_s[0] <= rd_s6;
			dv_c_s[0] <= c0;
			for (int j = 0; j < NDV; j++) begin
				dv_p_s[j+1] <= nx_p[j];
				dv_q_s[j+1] <= nx_q[j];
				dv_r_s[j+1] <= dv_r_s[j];
				dv_c_s[j+1] <= dv_c_s[j];
			end
		end
	end

	// rrd^2
	t1_t m1_in, m1_tag, m2_in, m2_tag;
	logic m1_v, m2_v;
	logic [MAG_W-1:0] m1_p, m2_p;
	logic m1_sat, m2_sat;

	always_comb begin
		m1_in.rrd = dv_c_s[NDV].sat ? LIM : dv_q_s[NDV];
		m1_in.c = dv_c_s[NDV];
		m2_in = m1_tag;
		m2_in.c.sat = m1_tag.c.sat | m1_sat;
	end

	ljpf_umulq #(.FRAC_BITS(FRAC_BITS), .TW($bits(t1_t))) u_m1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(dv_v_s[NDV]),
		.a(m1_in.rrd), .b(m1_in.rrd), .tag_in(m1_in),
		.vld_out(m1_v), .prod(m1_p), .sat(m1_sat), .tag_out(m1_tag)
	);

	// rrd^3
	ljpf_umulq #(.FRAC_BITS(FRAC_BITS), .TW($bits(t1_t))) u_m2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(m1_v),
		.a(m1_p), .b(m2_in.rrd), .tag_in(m2_in),
		.vld_out(m2_v), .prod(m2_p), .sat(m2_sat), .tag_out(m2_tag)
	);

	// rrd3 - 0.5 and rrd3 - 1.0
	logic [MAG_W-1:0] rrd3_s61, rrd_s61, hmag_s61, omag_s61;
	logic hneg_s61, oneg_s61, v_s61;
	ctx_t c_s61, c_n;
	logic [47:0] hd, od;

	always_comb begin
		hd = {1'b0, m2_p} - HALF;
		od = {1'b0, m2_p} - ONE;
		c_n = m2_tag.c;
		c_n.sat = m2_tag.c.sat | m2_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s61 <= 1'b0;
		end else if (en) begin
			v_s61 <= m2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rrd3_s61 <= m2_p;
			rrd_s61  <= m2_tag.rrd;
			hneg_s61 <= hd[47];
			oneg_s61 <= od[47];
			hmag_s61 <= hd[47] ? MAG_W'(-hd) : hd[MAG_W-1:0];
			omag_s61 <= od[47] ? MAG_W'(-od) : od[MAG_W-1:0];
			c_s61 <= c_n;
		end
	end

	// rrd^4 and energy
	t3_t m3_in, m3_tag;
	logic m3_v, m3b_v, m3_sat, m3b_sat;
	logic [MAG_W-1:0] m3_p, m3b_p;
	logic m3b_tag;

	always_comb begin
		m3_in.hmag = hmag_s61;
		m3_in.hneg = hneg_s61;
		m3_in.c = c_s61;
	end

	ljpf_umulq #(.FRAC_BITS(FRAC_BITS), .TW($bits(t3_t))) u_m3 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s61),
		.a(rrd3_s61), .b(rrd_s61), .tag_in(m3_in),
		.vld_out(m3_v), .prod(m3_p), .sat(m3_sat), .tag_out(m3_tag)
	);

	ljpf_umulq #(.FRAC_BITS(FRAC_BITS), .TW(1)) u_m3b (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s61),
		.a(rrd3_s61), .b(omag_s61), .tag_in(oneg_s61),
		.vld_out(m3b_v), .prod(m3b_p), .sat(m3b_sat), .tag_out(m3b_tag)
	);

	// r148
	t4_t m4_in, m4_tag;
	logic m4_v, m4_sat;
	logic [MAG_W-1:0] m4_p;

	always_comb begin
		m4_in.en_mag = m3b_p;
		m4_in.en_neg = m3b_tag;
		m4_in.rneg = m3_tag.hneg;
		m4_in.c = m3_tag.c;
		m4_in.c.sat = m3_tag.c.sat | m3_sat | m3b_sat;
	end

	ljpf_umulq #(.FRAC_BITS(FRAC_BITS), .TW($bits(t4_t))) u_m4 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(m3_v && m3b_v),
		.a(m3_p), .b(m3_tag.hmag), .tag_in(m4_in),
		.vld_out(m4_v), .prod(m4_p), .sat(m4_sat), .tag_out(m4_tag)
	);

	// virial and forces
	t4_t m5_in, m5_tag;
	logic m5_v, m5_sat;
	logic [MAG_W-1:0] m5_p;
	logic [2:0][MAG_W-1:0] dmag, fm_p;
	logic [2:0] fneg_in, fneg, fm_sat, fm_v;

	always_comb begin
		m5_in = m4_tag;
		m5_in.c.sat = m4_tag.c.sat | m4_sat;
		for (int c = 0; c < 3; c++) begin
			dmag[c] = m4_tag.c.d[c][32] ? MAG_W'(-$signed(m4_tag.c.d[c]))
				: MAG_W'(m4_tag.c.d[c]);
			fneg_in[c] = m4_tag.c.d[c][32] ^ m4_tag.rneg;
		end
	end

	ljpf_umulq #(.FRAC_BITS(FRAC_BITS), .TW($bits(t4_t))) u_m5 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(m4_v),
		.a(MAG_W'(m4_tag.c.rd)), .b(m4_p), .tag_in(m5_in),
		.vld_out(m5_v), .prod(m5_p), .sat(m5_sat), .tag_out(m5_tag)
	);

	for (genvar c = 0; c < 3; c++) begin : g_force
		ljpf_umulq #(.FRAC_BITS(FRAC_BITS), .TW(1)) u_mf (
			.clk(clk), .arst_n(arst_n), .en(en), .vld_in(m4_v),
			.a(dmag[c]), .b(m4_p), .tag_in(fneg_in[c]),
			.vld_out(fm_v[c]), .prod(fm_p[c]), .sat(fm_sat[c]), .tag_out(fneg[c])
		);
	end

	// result select
	out_t res;
	logic signed [47:0] fval [3];
	logic signed [33:0] dsg;

	always_comb begin
		res = '0;
		dsg = '0;
		for (int c = 0; c < 3; c++) begin
			fval[c] = fneg[c] ? -$signed({1'b0, fm_p[c]}) : $signed({1'b0, fm_p[c]});
		end
		if (m5_tag.c.inr) begin
			res.in_range = 1'b1;
			if (m5_tag.c.zero) begin
				res.saturated = 1'b1;
				for (int c = 0; c < 3; c++) begin
					dsg = $signed({m5_tag.c.d[c][32], m5_tag.c.d[c]});
					fval[c] = (dsg > 0) ? SLIM : ((dsg < 0) ? -SLIM : '0);
				end
				res.energy_term = SLIM;
				res.virial_term = -SLIM;
			end else begin
				res.saturated = m5_tag.c.sat | m5_sat | (|fm_sat);
				res.energy_term = m5_tag.en_neg ? -$signed({1'b0, m5_tag.en_mag})
					: $signed({1'b0, m5_tag.en_mag});
				res.virial_term = m5_tag.rneg ? $signed({1'b0, m5_p})
					: -$signed({1'b0, m5_p});
			end
			res.force_x = fval[0];
			res.force_y = fval[1];
			res.force_z = fval[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= m5_v && (&fm_v);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= res;
		end
	end

`ifndef SYNTHESIS
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_range |-> out_data.force_x == '0 &&
		out_data.force_y == '0 && out_data.force_z == '0 &&
		out_data.energy_term == '0 && out_data.virial_term == '0 && !out_data.saturated)
		else $error("nonzero result outside cutoff");

	a_sat_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> out_data.in_range)
		else $error("saturated flag without in_range");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dv_v_s) && $stable(v_s61))
		else $error("pipeline moved while stalled");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m5_v == (&fm_v) && m3_v == m3b_v)
		else $error("multiplier lanes out of step");
`endif

endmodule

FILE: tb/lennard_jones_pair_force_tb.sv
`timescale 1ns / 1ps

module lennard_jones_pair_force_tb;
	import ljpf_pkg::*;

	localparam int FB = 24;
	localparam logic [63:0] SAT_LIM = 64'h7FFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 400000;

	class lj_scoreboard;
		logic [31:0] box_side;
		logic [31:0] cutoff_sq;
		out_t        pending_q[$];
		int          n_err;
		int          n_checked;
		int          n_inrange;
		int          n_sat;
		bit          clip;

		function new();
			box_side  = 32'd424673280;
			cutoff_sq = 32'd235929600;
			n_err = 0;
			n_checked = 0;
			n_inrange = 0;
			n_sat = 0;
		endfunction

		function logic [63:0] umul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = ({64'b0, a} * {64'b0, b}) >> FB;
			if (p > SAT_LIM) begin
				clip = 1'b1;
				return SAT_LIM;
			end
			return p[63:0];
		endfunction

		function longint smul(longint a, longint b);
			logic [63:0] m;
			m = umul(a < 0 ? -a : a, b < 0 ? -b : b);
			return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
		endfunction

		function longint fold_diff(logic [31:0] pi, logic [31:0] pj);
			longint d, s;
			d = longint'({32'b0, pi}) - longint'({32'b0, pj});
			s = longint'({32'b0, box_side});
			if (2 * d < -s)
				d += s;
			if (2 * d > s)
				d -= s;
			return d;
		endfunction

		function out_t pair_terms(in_t p);
			longint       d[3];
			longint       f[3];
			longint       en, vir, r148, half, one;
			logic [127:0] sq, hsum, lsum, q;
			logic [63:0]  rd, rrd, rrd2, rrd3, rrd4, m;
			logic         inr;
			out_t         o;
			d[0] = fold_diff(p.pos_ix, p.pos_jx);
			d[1] = fold_diff(p.pos_iy, p.pos_jy);
			d[2] = fold_diff(p.pos_iz, p.pos_jz);
			hsum = 0;
			lsum = 0;
			clip = 1'b0;
			for (int c = 0; c < 3; c++) begin
				m = d[c] < 0 ? -d[c] : d[c];
				sq = {64'b0, m} * {64'b0, m};
				hsum += sq >> FB;
				lsum += sq & ((128'd1 << FB) - 1);
			end
			rd = 64'(hsum + (lsum >> FB));
			inr = rd <= {32'b0, cutoff_sq};
			for (int c = 0; c < 3; c++)
				f[c] = 0;
			en = 0;
			vir = 0;
			if (inr && rd == 0) begin
				clip = 1'b1;
				for (int c = 0; c < 3; c++)
					f[c] = d[c] > 0 ? longint'(SAT_LIM) : (d[c] < 0 ? -longint'(SAT_LIM) : 0);
				en = longint'(SAT_LIM);
				vir = -longint'(SAT_LIM);
			end else if (inr) begin
				q = (128'd1 << (2 * FB)) / {64'b0, rd};
				if (q > SAT_LIM) begin
					clip = 1'b1;
					rrd = SAT_LIM;
				end else begin
					rrd = q[63:0];
				end
				rrd2 = umul(rrd, rrd);
				rrd3 = umul(rrd2, rrd);
				rrd4 = umul(rrd3, rrd);
				half = longint'(1) << (FB - 1);
				one = longint'(1) << FB;
				r148 = smul(longint'(rrd4), longint'(rrd3) - half);
				en = smul(longint'(rrd3), longint'(rrd3) - one);
				vir = -smul(longint'(rd), r148);
				for (int c = 0; c < 3; c++)
					f[c] = smul(d[c], r148);
			end
			o.force_x = f[0][47:0];
			o.force_y = f[1][47:0];
			o.force_z = f[2][47:0];
			o.energy_term = en[47:0];
			o.virial_term = vir[47:0];
			o.in_range = inr;
			o.saturated = clip;
			return o;
		endfunction

		function void note_pair(in_t p);
			pending_q.push_back(pair_terms(p));
		endfunction

		function void check_result(out_t a);
			out_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result transaction");
				n_err++;
				return;
			end
			e = pending_q.pop_front();
			n_checked++;
			if (a.in_range)
				n_inrange++;
			if (a.saturated)
				n_sat++;
			if (a.force_x !== e.force_x) begin
				$error("force_x exp %h got %h", e.force_x, a.force_x);
				n_err++;
			end
			if (a.force_y !== e.force_y) begin
				$error("force_y exp %h got %h", e.force_y, a.force_y);
				n_err++;
			end
			if (a.force_z !== e.force_z) begin
				$error("force_z exp %h got %h", e.force_z, a.force_z);
				n_err++;
			end
			if (a.energy_term !== e.energy_term) begin
				$error("energy_term exp %h got %h", e.energy_term, a.energy_term);
				n_err++;
			end
			if (a.virial_term !== e.virial_term) begin
				$error("virial_term exp %h got %h", e.virial_term, a.virial_term);
				n_err++;
			end
			if (a.in_range !== e.in_range) begin
				$error("in_range exp %b got %b", e.in_range, a.in_range);
				n_err++;
			end
			if (a.saturated !== e.saturated) begin
				$error("saturated exp %b got %b", e.saturated, a.saturated);
				n_err++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	reg_idx_t    cfg_index;
	logic [31:0] cfg_data;

	lj_scoreboard sb;
	int           cycles;
	int           stall_pct;

	lennard_jones_pair_force u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls with a changing density, zero density included
	always @(negedge clk) begin
		if (cycles % 300 == 0)
			stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	task automatic send_pair(in_t p);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= p;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_pair(p);
	endtask

	task automatic pause_sender(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
			in_data <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_BOX_SIDE)
			sb.box_side = val;
		else
			sb.cutoff_sq = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic in_t mk_pair(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
			logic [31:0] jx, logic [31:0] jy, logic [31:0] jz);
		in_t p;
		p.pos_ix = ix;
		p.pos_iy = iy;
		p.pos_iz = iz;
		p.pos_jx = jx;
		p.pos_jy = jy;
		p.pos_jz = jz;
		return p;
	endfunction

	// mostly neighbor-like pairs: second particle near the first, sometimes across the wrap; the rest fully random
	function automatic in_t rand_pair();
		logic [31:0] pi[3];
		logic [31:0] pj[3];
		int          k, span;
		k = $urandom_range(0, 99);
		span = (k < 15) ? 64 : 32'h0400_0000;
		for (int c = 0; c < 3; c++) begin
			pi[c] = $urandom;
			if (k < 75)
				pj[c] = pi[c] + $urandom_range(0, 2 * span) - span;
			else
				pj[c] = $urandom;
			if (k < 75 && $urandom_range(0, 9) == 0)
				pj[c] = pj[c] ^ 32'h8000_0000;
		end
		return mk_pair(pi[0], pi[1], pi[2], pj[0], pj[1], pj[2]);
	endfunction

	task automatic run_random(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 24);
			for (int b = 0; b < burst && n > 0; b++, n--)
				send_pair(rand_pair());
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 6));
		end
		pause_sender(1);
	endtask

	initial begin
		logic [31:0] boxes[6];
		logic [31:0] cuts[6];
		sb = new();
		cycles = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BOX_SIDE;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset configuration
		send_pair(mk_pair(0, 0, 0, 0, 0, 0));
		send_pair(mk_pair('1, '1, '1, '1, '1, '1));
		send_pair(mk_pair('1, 0, 32'h1000_0000, 0, '1, 32'h1000_0000));
		send_pair(mk_pair(32'd62914560, 0, 0, 0, 0, 0));
		send_pair(mk_pair(0, 0, 0, 32'd62914560, 0, 0));
		send_pair(mk_pair(32'd62914561, 0, 0, 0, 0, 0));
		send_pair(mk_pair(5, 100, 0, 0, 100, 0));
		send_pair(mk_pair(0, 0, 0, 0, 1, 1));
		send_pair(mk_pair(32'h0100_0000, 32'h0200_0000, 0, 0, 0, 32'h0100_0000));
		send_pair(mk_pair(32'h1000_0000, 0, 0, 32'h0100_0000, 32'h1780_0000, 0));
		send_pair(mk_pair(32'h0180_0000, 32'h0080_0000, 32'h1950_0000,
				32'h0050_0000, 32'h1900_0000, 32'h0040_0000));
		send_pair(mk_pair(32'h0011_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		pause_sender(1);
		drain();

		boxes[0] = 32'd424673280; cuts[0] = 32'd235929600;
		boxes[1] = 32'd0;         cuts[1] = 32'hFFFF_FFFF;
		boxes[2] = 32'hFFFF_FFFF; cuts[2] = 32'hFFFF_FFFF;
		boxes[3] = 32'hFFFF_FFFF; cuts[3] = 32'd0;
		boxes[4] = 32'h0100_0000; cuts[4] = 32'h0400_0000;
		boxes[5] = 32'h1000_0000; cuts[5] = 32'h0900_0000;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_BOX_SIDE, boxes[ph]);
			write_reg(REG_CUTOFF_SQ, cuts[ph]);
			if (ph == 3)
				send_pair(mk_pair(7, 0, 0, 7, 0, 0));
			run_random(200);
			drain();
		end

		$display("%0d pair results checked over 6 box/cutoff settings: %0d in range, %0d clipped",
				sb.n_checked, sb.n_inrange, sb.n_sat);
		if (sb.n_err == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
